// ----- rtl/core/wtrp_pkg.sv -----
// ----------------------------------------------------------------------------
// wtrp_pkg
// Shared types, codes and constants of the weighted table random pick core.
// ----------------------------------------------------------------------------
`default_nettype none

package wtrp_pkg;

   // default table depth
   localparam int unsigned MAX_ENTRIES_DEF = 64;

   // command codes
   localparam logic [2:0] CMD_CLEAR  = 3'd0;
   localparam logic [2:0] CMD_APPEND = 3'd1;
   localparam logic [2:0] CMD_ROLL   = 3'd2;
   localparam logic [2:0] CMD_VALUE  = 3'd3;
   localparam logic [2:0] CMD_SCALED = 3'd4;

   // status codes
   localparam logic [2:0] STAT_OK         = 3'd0;
   localparam logic [2:0] STAT_FULL       = 3'd1;
   localparam logic [2:0] STAT_BAD_RARITY = 3'd2;
   localparam logic [2:0] STAT_NO_WEIGHT  = 3'd3;
   localparam logic [2:0] STAT_BAD_INDEX  = 3'd4;

   localparam logic [2:0] RARITY_MAX = 3'd4;

   // generator and fixed point constants
   localparam logic [31:0] LCG_MUL  = 32'd1664525;
   localparam logic [31:0] LCG_ADD  = 32'd1013904223;
   localparam logic [24:0] FRAC_ONE = 25'h100_0000;
   localparam logic [15:0] Q_ONE    = 16'd4096;
   localparam logic [15:0] Q_FOUR   = 16'd16384;

   // shared divider and multiplier widths
   localparam int unsigned DIV_NUM_W = 38;
   localparam int unsigned DIV_DEN_W = 32;
   localparam int unsigned MUL_W     = 32;

   typedef struct packed {
      logic             cls;
      logic [15:0]      min_v;
      logic [15:0]      max_v;
      logic [4:0][15:0] w;
   } entry_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DECODE, S_SUM, S_SUM_END, S_CHECK, S_RANGE, S_LCG_MUL, S_LCG_ADD,
      S_Y_RAW, S_MUL_K, S_DIV, S_DIV_WAIT, S_PICK, S_PICK_END, S_MUL_Y, S_Y_LOAD,
      S_MUL_OFF, S_OFF_TAKE, S_RESP
   } state_type;

   typedef enum logic [1:0] {MUL_LCG, MUL_K, MUL_Y, MUL_OFF} mul_sel_type;
   typedef enum logic [1:0] {DIV_PICK, DIV_SPAN, DIV_K} div_sel_type;

   // controller to datapath
   typedef struct packed {
      logic        ready;
      logic        capture;
      logic        clear;
      logic        append;
      logic        scan_start;
      logic        scan_issue;
      logic        fetch;
      logic        sum_en;
      logic        pick_en;
      logic        range_load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        lcg_add;
      logic        div_start;
      logic        div_take;
      div_sel_type div_sel;
      logic        y_raw;
      logic        y_load;
      logic        off_take;
      logic        stat_load;
      logic [2:0]  stat_code;
      logic        rsp_load;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       req_valid;
      logic [2:0] cmd;
      logic       full;
      logic       bad_rarity;
      logic       bad_index;
      logic       count_zero;
      logic       total_zero;
      logic       q_scale;
      logic       scan_last;
      logic       div_done;
      logic       rsp_free;
   } dp_stat_type;

endpackage

`default_nettype wire

// ----- rtl/core/wtrp_req_if.sv -----
// ----------------------------------------------------------------------------
// wtrp_req_if
// Request channel: one command item per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface wtrp_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic        entry_class;
   logic signed [15:0] low_bound;
   logic signed [15:0] high_bound;
   logic [15:0] weight_0;
   logic [15:0] weight_1;
   logic [15:0] weight_2;
   logic [15:0] weight_3;
   logic [15:0] weight_4;
   logic [2:0]  rarity;
   logic [5:0]  entry_index;
   logic [15:0] quality;

   modport source (
      output valid, cmd, entry_class, low_bound, high_bound,
             weight_0, weight_1, weight_2, weight_3, weight_4,
             rarity, entry_index, quality,
      input  ready
   );
   modport sink (
      input  valid, cmd, entry_class, low_bound, high_bound,
             weight_0, weight_1, weight_2, weight_3, weight_4,
             rarity, entry_index, quality,
      output ready
   );
endinterface

`default_nettype wire

// ----- rtl/core/wtrp_rsp_if.sv -----
// ----------------------------------------------------------------------------
// wtrp_rsp_if
// Response channel: one result item per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface wtrp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [5:0]  picked_index;
   logic signed [15:0] rolled_value;
   logic [6:0]  entry_count;

   modport source (
      output valid, status, picked_index, rolled_value, entry_count,
      input  ready
   );
   modport sink (
      input  valid, status, picked_index, rolled_value, entry_count,
      output ready
   );
endinterface

`default_nettype wire

// ----- rtl/core/wtrp_div.sv -----
// ----------------------------------------------------------------------------
// wtrp_div
// Restoring divider, one quotient bit per cycle, quotient and remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module wtrp_div #(
   parameter int unsigned NUM_W = 38,
   parameter int unsigned DEN_W = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output      logic             done,
   output      logic [NUM_W-1:0] quot,
   output      logic [DEN_W-1:0] rem
);
   localparam int unsigned CW = $clog2(NUM_W);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   // one shift and trial subtract per cycle
   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      fits    = trial >= {1'b0, den_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         quo_in = num;
         rem_in = '0;
         den_in = den;
      end else if (run_ff) begin
         quo_in = {quo_ff[NUM_W-2:0], fits};
         rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(NUM_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;
   assign rem  = rem_ff;
endmodule

`default_nettype wire

// ----- rtl/core/wtrp_ctrl.sv -----
// ----------------------------------------------------------------------------
// wtrp_ctrl
// Command sequencer: steps each item through scan, generator, divide and
// multiply phases of the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module wtrp_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire wtrp_pkg::dp_stat_type stat,
   output      wtrp_pkg::dp_cmd_type  cmd
);
   import wtrp_pkg::*;

   state_type   state_ff, state_in;
   div_sel_type dsel;

   // divide job follows the command
   always_comb begin
      case (stat.cmd)
         CMD_ROLL:  dsel = DIV_PICK;
         CMD_VALUE: dsel = DIV_SPAN;
         default:   dsel = DIV_K;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (stat.req_valid) state_in = S_DECODE;
         S_DECODE: begin
            case (stat.cmd)
               CMD_ROLL: begin
                  if (stat.bad_rarity || stat.count_zero) state_in = S_RESP;
                  else state_in = S_SUM;
               end
               CMD_VALUE, CMD_SCALED: begin
                  if (stat.bad_index) state_in = S_RESP;
                  else state_in = S_RANGE;
               end
               default: state_in = S_RESP;
            endcase
         end
         S_SUM:     if (stat.scan_last) state_in = S_SUM_END;
         S_SUM_END: state_in = S_CHECK;
         S_CHECK:   state_in = stat.total_zero ? S_RESP : S_LCG_MUL;
         S_RANGE:   state_in = S_LCG_MUL;
         S_LCG_MUL: state_in = S_LCG_ADD;
         S_LCG_ADD: begin
            if (stat.cmd == CMD_SCALED) state_in = stat.q_scale ? S_MUL_K : S_Y_RAW;
            else state_in = S_DIV;
         end
         S_Y_RAW:  state_in = S_MUL_OFF;
         S_MUL_K:  state_in = S_DIV;
         S_DIV:    state_in = S_DIV_WAIT;
         S_DIV_WAIT: begin
            if (stat.div_done) begin
               case (dsel)
                  DIV_PICK: state_in = S_PICK;
                  DIV_SPAN: state_in = S_RESP;
                  default:  state_in = S_MUL_Y;
               endcase
            end
         end
         S_PICK:     if (stat.scan_last) state_in = S_PICK_END;
         S_PICK_END: state_in = S_RESP;
         S_MUL_Y:    state_in = S_Y_LOAD;
         S_Y_LOAD:   state_in = S_MUL_OFF;
         S_MUL_OFF:  state_in = S_OFF_TAKE;
         S_OFF_TAKE: state_in = S_RESP;
         S_RESP:     if (stat.rsp_free) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd         = '0;
      cmd.div_sel = dsel;
      case (state_ff)
         S_IDLE: begin
            cmd.ready   = 1'b1;
            cmd.capture = stat.req_valid;
         end
         S_DECODE: begin
            case (stat.cmd)
               CMD_CLEAR: cmd.clear = 1'b1;
               CMD_APPEND: begin
                  if (stat.full) begin
                     cmd.stat_load = 1'b1;
                     cmd.stat_code = STAT_FULL;
                  end else begin
                     cmd.append = 1'b1;
                  end
               end
               CMD_ROLL: begin
                  if (stat.bad_rarity) begin
                     cmd.stat_load = 1'b1;
                     cmd.stat_code = STAT_BAD_RARITY;
                  end else if (stat.count_zero) begin
                     cmd.stat_load = 1'b1;
                     cmd.stat_code = STAT_NO_WEIGHT;
                  end else begin
                     cmd.scan_start = 1'b1;
                  end
               end
               CMD_VALUE, CMD_SCALED: begin
                  if (stat.bad_index) begin
                     cmd.stat_load = 1'b1;
                     cmd.stat_code = STAT_BAD_INDEX;
                  end else begin
                     cmd.fetch = 1'b1;
                  end
               end
               default: cmd.stat_code = STAT_OK;
            endcase
         end
         S_SUM: begin
            cmd.scan_issue = 1'b1;
            cmd.sum_en     = 1'b1;
         end
         S_SUM_END: cmd.sum_en = 1'b1;
         S_CHECK: begin
            cmd.stat_load = stat.total_zero;
            cmd.stat_code = STAT_NO_WEIGHT;
         end
         S_RANGE: cmd.range_load = 1'b1;
         S_LCG_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_LCG;
         end
         S_LCG_ADD: cmd.lcg_add = 1'b1;
         S_Y_RAW:   cmd.y_raw = 1'b1;
         S_MUL_K: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_K;
         end
         S_DIV:      cmd.div_start = 1'b1;
         S_DIV_WAIT: begin
            cmd.div_take   = stat.div_done;
            cmd.scan_start = stat.div_done && (dsel == DIV_PICK);
         end
         S_PICK: begin
            cmd.scan_issue = 1'b1;
            cmd.pick_en    = 1'b1;
         end
         S_PICK_END: cmd.pick_en = 1'b1;
         S_MUL_Y: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_Y;
         end
         S_Y_LOAD: cmd.y_load = 1'b1;
         S_MUL_OFF: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_OFF;
         end
         S_OFF_TAKE: cmd.off_take = 1'b1;
         S_RESP:     cmd.rsp_load = stat.rsp_free;
         default:    cmd.ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

`default_nettype wire

// ----- rtl/core/wtrp_dp.sv -----
// ----------------------------------------------------------------------------
// wtrp_dp
// Datapath: entry table memory, generator, shared multiplier and divider,
// scan accumulators and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wtrp_dp #(
   parameter int unsigned MAX_ENTRIES = wtrp_pkg::MAX_ENTRIES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   wtrp_req_if.sink                   req_if,
   wtrp_rsp_if.source                 rsp_if,
   input  wire logic                  csr_we,
   input  wire logic [31:0]           csr_wdata,
   input  wire wtrp_pkg::dp_cmd_type  cmd,
   output      wtrp_pkg::dp_stat_type stat
);
   import wtrp_pkg::*;

   localparam int unsigned AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int unsigned TOT_W = 16 + CNT_W;
   localparam int unsigned IW    = (CNT_W > 6) ? CNT_W : 6;

   // entry table
   entry_type mem [MAX_ENTRIES];
   entry_type rd_data_ff;
   entry_type wr_data;
   logic [AW-1:0] rd_addr;

   // captured item
   logic [2:0]       cmd_ff;
   logic             cls_ff;
   logic [15:0]      min_ff, max_ff;
   logic [4:0][15:0] w_ff;
   logic [2:0]       rar_ff;
   logic [5:0]       idx_ff;
   logic [15:0]      q_ff;

   // control state
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]      gen_ff, gen_in;
   logic [AW-1:0]    scan_ff, scan_in;
   logic             rd_vld_ff;
   logic             found_ff, found_in;
   logic [2:0]       stat_ff, stat_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [AW-1:0]    rd_idx_ff;
   logic [TOT_W-1:0] total_ff, total_in;
   logic [TOT_W-1:0] acc_ff, acc_in;
   logic [31:0]      pick_ff, pick_in;
   logic [AW-1:0]    picked_ff, picked_in;
   logic [15:0]      lo_ff;
   logic [16:0]      span_ff;
   logic [63:0]      mul_ff;
   logic [24:0]      k_ff, k_in;
   logic [24:0]      y_ff, y_in;
   logic [15:0]      value_ff, value_in;

   // result register
   logic [2:0]  rsp_status_ff;
   logic [5:0]  rsp_picked_ff;
   logic [15:0] rsp_value_ff;
   logic [6:0]  rsp_count_ff;

   logic [15:0]      w_sel;
   logic             hit;
   logic [TOT_W-1:0] acc_sum;
   logic [MUL_W-1:0] mul_a, mul_b;
   logic [16:0]      span_new;
   logic [16:0]      off_raw, off_lim;
   logic [CNT_W-1:0] scan_next;

   logic                 div_done;
   logic [DIV_NUM_W-1:0] div_num, div_quot;
   logic [DIV_DEN_W-1:0] div_den, div_rem;

   // table write and registered read
   always_comb begin
      wr_data.cls   = cls_ff;
      wr_data.min_v = min_ff;
      wr_data.max_v = ($signed(max_ff) < $signed(min_ff)) ? min_ff : max_ff;
      wr_data.w     = w_ff;
      rd_addr       = cmd.fetch ? AW'(idx_ff) : scan_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.append) begin
         mem[count_ff[AW-1:0]] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // weight of the rolled rarity in the entry just read
   always_comb begin
      case (rar_ff)
         3'd0:    w_sel = rd_data_ff.w[0];
         3'd1:    w_sel = rd_data_ff.w[1];
         3'd2:    w_sel = rd_data_ff.w[2];
         3'd3:    w_sel = rd_data_ff.w[3];
         3'd4:    w_sel = rd_data_ff.w[4];
         default: w_sel = '0;
      endcase
      hit     = rd_vld_ff && (rd_data_ff.cls == cls_ff) && (w_sel != '0);
      acc_sum = acc_ff + TOT_W'(w_sel);
   end

   // shared multiplier operands
   always_comb begin
      case (cmd.mul_sel)
         MUL_LCG: begin
            mul_a = gen_ff;
            mul_b = LCG_MUL;
         end
         MUL_K: begin
            mul_a = MUL_W'(q_ff - Q_ONE);
            mul_b = MUL_W'(FRAC_ONE - {1'b0, gen_ff[23:0]});
         end
         MUL_Y: begin
            mul_a = MUL_W'(gen_ff[23:0]);
            mul_b = MUL_W'(FRAC_ONE + k_ff);
         end
         default: begin
            mul_a = MUL_W'(y_ff);
            mul_b = MUL_W'(span_ff);
         end
      endcase
   end

   // shared divider operands
   always_comb begin
      case (cmd.div_sel)
         DIV_PICK: begin
            div_num = DIV_NUM_W'(gen_ff);
            div_den = DIV_DEN_W'(total_ff);
         end
         DIV_SPAN: begin
            div_num = DIV_NUM_W'(gen_ff);
            div_den = DIV_DEN_W'(span_ff);
         end
         default: begin
            div_num = mul_ff[DIV_NUM_W-1:0];
            div_den = DIV_DEN_W'(q_ff);
         end
      endcase
   end

   wtrp_div #(
      .NUM_W (DIV_NUM_W),
      .DEN_W (DIV_DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   // range of the fetched entry and clamped scaled offset
   always_comb begin
      span_new = 17'({rd_data_ff.max_v[15], rd_data_ff.max_v}
                     - {rd_data_ff.min_v[15], rd_data_ff.min_v}) + 17'd1;
      off_raw  = mul_ff[40:24];
      off_lim  = (off_raw >= span_ff) ? span_ff - 17'd1 : off_raw;
   end

   // control and working register updates
   always_comb begin
      count_in     = count_ff;
      gen_in       = gen_ff;
      scan_in      = scan_ff;
      found_in     = found_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff;
      total_in     = total_ff;
      acc_in       = acc_ff;
      pick_in      = pick_ff;
      picked_in    = picked_ff;
      k_in         = k_ff;
      y_in         = y_ff;
      value_in     = value_ff;

      if (cmd.capture) begin
         stat_in   = STAT_OK;
         found_in  = 1'b0;
         picked_in = '0;
         value_in  = '0;
      end
      if (cmd.clear)  count_in = '0;
      if (cmd.append) count_in = count_ff + CNT_W'(1);
      if (cmd.stat_load) stat_in = cmd.stat_code;

      if (cmd.scan_start) begin
         scan_in  = '0;
         total_in = '0;
         acc_in   = '0;
      end else if (cmd.scan_issue) begin
         scan_in = scan_ff + AW'(1);
      end

      if (cmd.sum_en && rd_vld_ff && (rd_data_ff.cls == cls_ff)) begin
         total_in = total_ff + TOT_W'(w_sel);
      end
      if (cmd.pick_en && hit) begin
         acc_in = acc_sum;
         if (!found_ff && (pick_ff < DIV_DEN_W'(acc_sum))) begin
            found_in  = 1'b1;
            picked_in = rd_idx_ff;
         end
      end

      if (cmd.lcg_add) gen_in = mul_ff[31:0] + LCG_ADD;
      if (csr_we)      gen_in = csr_wdata;

      if (cmd.div_take) begin
         case (cmd.div_sel)
            DIV_PICK: pick_in  = div_rem;
            DIV_SPAN: value_in = lo_ff + div_rem[15:0];
            default:  k_in     = div_quot[24:0];
         endcase
      end
      if (cmd.y_raw)    y_in     = 25'(gen_ff[23:0]);
      if (cmd.y_load)   y_in     = mul_ff[48:24];
      if (cmd.off_take) value_in = lo_ff + off_lim[15:0];

      if (cmd.rsp_load)     rsp_valid_in = 1'b1;
      else if (rsp_if.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         gen_ff       <= '0;
         scan_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         stat_ff      <= STAT_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         gen_ff       <= gen_in;
         scan_ff      <= scan_in;
         rd_vld_ff    <= cmd.scan_issue;
         found_ff     <= found_in;
         stat_ff      <= stat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item capture, working and result payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff <= req_if.cmd;
         cls_ff <= req_if.entry_class;
         min_ff <= req_if.low_bound;
         max_ff <= req_if.high_bound;
         w_ff   <= {req_if.weight_4, req_if.weight_3, req_if.weight_2,
                    req_if.weight_1, req_if.weight_0};
         rar_ff <= req_if.rarity;
         idx_ff <= req_if.entry_index;
         q_ff   <= req_if.quality;
      end
      if (cmd.range_load) begin
         lo_ff   <= rd_data_ff.min_v;
         span_ff <= span_new;
      end
      if (cmd.mul_en) mul_ff <= {32'd0, mul_a} * {32'd0, mul_b};
      rd_idx_ff <= scan_ff;
      total_ff  <= total_in;
      acc_ff    <= acc_in;
      pick_ff   <= pick_in;
      picked_ff <= picked_in;
      k_ff      <= k_in;
      y_ff      <= y_in;
      value_ff  <= value_in;
      if (cmd.rsp_load) begin
         rsp_status_ff <= stat_ff;
         rsp_picked_ff <= 6'(picked_ff);
         rsp_value_ff  <= value_ff;
         rsp_count_ff  <= 7'(count_ff);
      end
   end

   // status to the controller
   always_comb begin
      scan_next       = CNT_W'(scan_ff) + CNT_W'(1);
      stat.req_valid  = req_if.valid;
      stat.cmd        = cmd_ff;
      stat.full       = count_ff == CNT_W'(MAX_ENTRIES);
      stat.bad_rarity = rar_ff > RARITY_MAX;
      stat.bad_index  = IW'(idx_ff) >= IW'(count_ff);
      stat.count_zero = count_ff == '0;
      stat.total_zero = total_ff == '0;
      stat.q_scale    = (q_ff > Q_ONE) && (q_ff <= Q_FOUR);
      stat.scan_last  = scan_next == count_ff;
      stat.div_done   = div_done;
      stat.rsp_free   = !rsp_valid_ff || rsp_if.ready;
   end

   assign req_if.ready        = cmd.ready;
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = rsp_status_ff;
   assign rsp_if.picked_index = rsp_picked_ff;
   assign rsp_if.rolled_value = rsp_value_ff;
   assign rsp_if.entry_count  = rsp_count_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count beyond table depth");

   a_gen_source: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (gen_ff != $past(gen_ff))) |-> $past(cmd.lcg_add || csr_we))
      else $error("generator changed without a step or seed write");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> (div_den != '0))
      else $error("divider started with zero divisor");

   a_roll_found: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_load && (cmd_ff == CMD_ROLL) && (stat_ff == STAT_OK)) |-> found_ff)
      else $error("weighted roll finished without a pick");
`endif
endmodule

`default_nettype wire

// ----- rtl/core/weighted_table_random_pick_core.sv -----
// ----------------------------------------------------------------------------
// weighted_table_random_pick_core
// Entry table with weighted pick and range rolls driven by an internal LCG.
//
//   port     direction  transfer content
//   req_if   in         one command with entry fields, rarity, index, quality
//   rsp_if   out        status, picked index, rolled value, entry count
//   csr_*    in         generator seed write, no read-back
//
// Clear, append, unknown commands and rejected rolls go straight to the
// response; a value roll runs the 38-step bit-serial divider once. A scaled
// roll multiplies for the generator and offset; the quality skew adds one
// divide, two multiplies. Weighted rolls scan the table twice, divide once.
// Reset is synchronous; it clears the table count and loads a zero seed.
// A new item is taken once the previous one has reached the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_table_random_pick_core #(
   parameter int unsigned MAX_ENTRIES = wtrp_pkg::MAX_ENTRIES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   wtrp_req_if.sink         req_if,
   wtrp_rsp_if.source       rsp_if,
   input  wire logic        csr_we,
   input  wire logic [31:0] csr_wdata
);
   import wtrp_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencer
   wtrp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   // table, generator and arithmetic
   wtrp_dp #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat)
   );
endmodule

`default_nettype wire
